// ===== rtl/stac_pkg.sv =====
// Shared constants for the sparse triplet accumulator: store geometry,
// operation, status and register codes, stream widths, adder hand-off.
// No dependencies.
`timescale 1ns / 1ps
package stac_pkg;

  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned AW       = $clog2(CAPACITY);
  localparam int unsigned CW       = AW + 1;
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned VAL_W    = 64;
  localparam int unsigned ENTRY_W  = KEY_W + VAL_W;

  // Stream widths
  localparam int unsigned S_TDATA_W = 144;
  localparam int unsigned M_TDATA_W = 144;

  // Operation codes carried in tuser
  localparam logic [2:0] MODE_CLEAR   = 3'd0;
  localparam logic [2:0] MODE_INSERT  = 3'd1;
  localparam logic [2:0] MODE_SORT    = 3'd2;
  localparam logic [2:0] MODE_COMPACT = 3'd3;
  localparam logic [2:0] MODE_LOOKUP  = 3'd4;
  localparam logic [2:0] MODE_READ    = 3'd5;

  // Status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;
  localparam logic [1:0] STAT_POS   = 2'd3;

  // Configuration register indexes
  localparam logic REG_ROW_LIMIT = 1'b0;
  localparam logic REG_COL_LIMIT = 1'b1;

  // Adder hand-off between sequencer and floating-point unit
  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } add_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] sum;
  } add_rsp_t;

endpackage

// ===== rtl/stac_ram.sv =====
// One bank of entry storage: key and value per word, one write port and
// one registered read port. Depends on stac_pkg.
`timescale 1ns / 1ps
module stac_ram (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [stac_pkg::AW-1:0]          waddr_i,
  input  logic [stac_pkg::ENTRY_W-1:0]     wdata_i,
  input  logic [stac_pkg::AW-1:0]          raddr_i,
  output logic [stac_pkg::ENTRY_W-1:0]     rdata_o
);

  logic [stac_pkg::ENTRY_W-1:0] mem [stac_pkg::CAPACITY];
  logic [stac_pkg::ENTRY_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/stac_fp_add.sv =====
// Multi-cycle binary64 adder, round to nearest even, normalizing one bit
// per cycle. Depends on stac_pkg for the request and response structs.
`timescale 1ns / 1ps
module stac_fp_add (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  stac_pkg::add_req_t  req_i,
  output stac_pkg::add_rsp_t  rsp_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_ALIGN = 3'd2;
  localparam logic [2:0] S_NORM  = 3'd3;
  localparam logic [2:0] S_ROUND = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  localparam logic [63:0] QNAN_BIT    = 64'h0008_0000_0000_0000;
  localparam logic [63:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;

  logic [2:0]  state_q, state_d;
  logic [63:0] a_q, a_d, b_q, b_d, res_q, res_d;
  logic [55:0] xm_q, xm_d, ym_q, ym_d;
  logic [56:0] s_q, s_d;
  logic [11:0] e_q, e_d;
  logic [10:0] dexp_q, dexp_d;
  logic        sign_q, sign_d, sub_q, sub_d;

  // unpack helpers
  logic        a_nan, b_nan, a_inf, b_inf, a_big;
  logic [63:0] big, sml;
  logic [11:0] ex_big, ex_sml;
  // align helpers
  logic [55:0] ys, mask;
  logic        sticky;
  logic [56:0] sum;
  // round helpers
  logic        up;
  logic [53:0] m54;
  logic [11:0] e2;
  logic [51:0] frac;

  always_comb begin
    a_nan  = (a_q[62:52] == 11'h7FF) && (a_q[51:0] != 52'd0);
    b_nan  = (b_q[62:52] == 11'h7FF) && (b_q[51:0] != 52'd0);
    a_inf  = (a_q[62:52] == 11'h7FF) && (a_q[51:0] == 52'd0);
    b_inf  = (b_q[62:52] == 11'h7FF) && (b_q[51:0] == 52'd0);
    a_big  = a_q[62:0] >= b_q[62:0];
    big    = a_big ? a_q : b_q;
    sml    = a_big ? b_q : a_q;
    ex_big = (big[62:52] == 11'd0) ? 12'd1 : {1'b0, big[62:52]};
    ex_sml = (sml[62:52] == 11'd0) ? 12'd1 : {1'b0, sml[62:52]};

    mask = (56'd1 << dexp_q[5:0]) - 56'd1;
    if (dexp_q >= 11'd56) begin
      ys     = 56'd0;
      sticky = |ym_q;
    end else begin
      ys     = ym_q >> dexp_q[5:0];
      sticky = |(ym_q & mask);
    end
    ys[0] = ys[0] | sticky;
    sum   = sub_q ? ({1'b0, xm_q} - {1'b0, ys}) : ({1'b0, xm_q} + {1'b0, ys});

    up  = s_q[2] & (s_q[1] | s_q[0] | s_q[3]);
    m54 = {1'b0, s_q[55:3]} + {53'd0, up};
    if (m54[53]) begin
      e2   = e_q + 12'd1;
      frac = m54[52:1];
    end else begin
      e2   = m54[52] ? e_q : 12'd0;
      frac = m54[51:0];
    end
  end

  always_comb begin
    state_d = state_q;
    a_d     = a_q;
    b_d     = b_q;
    res_d   = res_q;
    xm_d    = xm_q;
    ym_d    = ym_q;
    s_d     = s_q;
    e_d     = e_q;
    dexp_d  = dexp_q;
    sign_d  = sign_q;
    sub_d   = sub_q;
    case (state_q)
      S_IDLE: begin
        if (req_i.start) begin
          a_d     = req_i.a;
          b_d     = req_i.b;
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        if (a_nan) begin
          res_d   = a_q | QNAN_BIT;
          state_d = S_DONE;
        end else if (b_nan) begin
          res_d   = b_q | QNAN_BIT;
          state_d = S_DONE;
        end else if (a_inf) begin
          res_d   = (b_inf && (a_q[63] != b_q[63])) ? DEFAULT_NAN : a_q;
          state_d = S_DONE;
        end else if (b_inf) begin
          res_d   = b_q;
          state_d = S_DONE;
        end else begin
          xm_d    = {(big[62:52] != 11'd0), big[51:0], 3'b000};
          ym_d    = {(sml[62:52] != 11'd0), sml[51:0], 3'b000};
          e_d     = ex_big;
          dexp_d  = 11'(ex_big - ex_sml);
          sign_d  = big[63];
          sub_d   = a_q[63] ^ b_q[63];
          state_d = S_ALIGN;
        end
      end
      S_ALIGN: begin
        if (sum == 57'd0) begin
          res_d   = {(sub_q ? 1'b0 : sign_q), 63'd0};
          state_d = S_DONE;
        end else if (sum[56]) begin
          s_d     = {1'b0, sum[56:2], sum[1] | sum[0]};
          e_d     = e_q + 12'd1;
          state_d = S_NORM;
        end else begin
          s_d     = sum;
          state_d = S_NORM;
        end
      end
      S_NORM: begin
        if (!s_q[55] && (e_q > 12'd1)) begin
          s_d = {s_q[55:0], 1'b0};
          e_d = e_q - 12'd1;
        end else begin
          state_d = S_ROUND;
        end
      end
      S_ROUND: begin
        if (e2 >= 12'd2047) begin
          res_d = {sign_q, 11'h7FF, 52'd0};
        end else begin
          res_d = {sign_q, e2[10:0], frac};
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    res_q  <= res_d;
    xm_q   <= xm_d;
    ym_q   <= ym_d;
    s_q    <= s_d;
    e_q    <= e_d;
    dexp_q <= dexp_d;
    sign_q <= sign_d;
    sub_q  <= sub_d;
  end

  assign rsp_o.done = (state_q == S_DONE);
  assign rsp_o.sum  = res_q;

endmodule

// ===== rtl/sparse_triplet_accumulator_unit.sv =====
// Top level of the sparse triplet accumulator: stream ports, operation
// sequencer, two storage banks and the binary64 adder.
// Depends on stac_pkg, stac_ram and stac_fp_add.
`timescale 1ns / 1ps
// Usage:
// Each transaction on the slave stream carries one operation (tuser) and
// its operands (tdata); each one returns exactly one result transaction
// on the master stream: value, row, column, found flag and entry count
// in tdata, status in tuser. Configuration writes (row and column limits)
// go through cfg_we_i / cfg_idx_i / cfg_data_i while the block is idle.
// Clear, insert, rejected operations and unused codes answer from the
// idle state and may follow back to back while the receiver takes each
// result. Read by position passes through the read state. Lookup reads
// the store in order, one store read per cycle, up to the first match.
// Compact sums adjacent entries of equal key in the adder. Sort is a
// bottom-up merge over ceil(log2 n) passes, bound by the single read
// port of the source bank. s_axis_tready is low while an operation is
// at work. The result sits in an output register; a stalled receiver
// holds it and blocks the next transaction until it is taken.
// Reset empties the store and sets both limits to all ones; the storage
// itself is not cleared.
module sparse_triplet_accumulator_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  // slave stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // row [31:0], col [63:32], value_bits [127:64], position [137:128]
  input  logic [143:0] s_axis_tdata,
  // mode [2:0]
  input  logic [2:0]   s_axis_tuser,
  // master stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_value_bits [63:0], out_row [95:64], out_col [127:96], found [128],
  // entry_count [139:129]
  output logic [143:0] m_axis_tdata,
  // status [1:0]
  output logic [1:0]   m_axis_tuser,
  // configuration
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [31:0]  cfg_data_i
);

  localparam int unsigned AW = stac_pkg::AW;
  localparam int unsigned CW = stac_pkg::CW;
  localparam int unsigned EW = stac_pkg::ENTRY_W;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_RD       = 4'd1;
  localparam logic [3:0] ST_LK       = 4'd2;
  localparam logic [3:0] ST_CP_FIRST = 4'd3;
  localparam logic [3:0] ST_CP_ISSUE = 4'd4;
  localparam logic [3:0] ST_CP_RUN   = 4'd5;
  localparam logic [3:0] ST_CP_ADD   = 4'd6;
  localparam logic [3:0] ST_CP_END   = 4'd7;
  localparam logic [3:0] ST_SO_SETUP = 4'd8;
  localparam logic [3:0] ST_SO_LDA   = 4'd9;
  localparam logic [3:0] ST_SO_LDB   = 4'd10;
  localparam logic [3:0] ST_SO_CMP   = 4'd11;

  // input fields
  logic [31:0] in_row, in_col;
  logic [63:0] in_val;
  logic [9:0]  in_pos;
  logic [2:0]  in_mode;
  logic        in_acc;

  assign in_row  = s_axis_tdata[31:0];
  assign in_col  = s_axis_tdata[63:32];
  assign in_val  = s_axis_tdata[127:64];
  assign in_pos  = s_axis_tdata[137:128];
  assign in_mode = s_axis_tuser;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          cur_q, cur_d;
  logic [31:0]   row_lim_q, col_lim_q;
  logic [CW-1:0] idx_q, idx_d;
  logic [AW-1:0] w_q, w_d;
  logic [63:0]   key_q, key_d;
  logic [63:0]   acc_key_q, acc_key_d, acc_val_q, acc_val_d;
  logic [CW-1:0] width_q, width_d;
  logic [CW:0]   lo_q, lo_d;
  logic [CW-1:0] mid_q, mid_d, hi_q, hi_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic [EW-1:0] a_q, a_d, b_q, b_d;
  logic          first_q, first_d;

  // output register
  logic        ovld_q;
  logic [63:0] o_val_q;
  logic [31:0] o_row_q, o_col_q;
  logic        o_found_q;
  logic [CW-1:0] o_cnt_q;
  logic [1:0]  o_stat_q;

  // result to load this cycle
  logic        res_load;
  logic [63:0] res_val;
  logic [31:0] res_row, res_col;
  logic        res_found;
  logic [1:0]  res_stat;

  // storage access
  logic          we, wbank;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rd0, rd1, rdata;

  stac_pkg::add_req_t add_req;
  stac_pkg::add_rsp_t add_rsp;

  // sort helpers
  logic [CW+1:0] mid_sum, hi_sum, lo_next;
  logic [CW-1:0] mid_c, hi_c;
  logic          av_a, av_b, take_b;
  logic [CW-1:0] width_dbl;

  assign rdata = cur_q ? rd1 : rd0;

  stac_ram u_bank0 (
    .clk_i  (clk_i),
    .we_i   (we && !wbank),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rd0)
  );

  stac_ram u_bank1 (
    .clk_i  (clk_i),
    .we_i   (we && wbank),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rd1)
  );

  stac_fp_add u_add (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (add_req),
    .rsp_o (add_rsp)
  );

  assign s_axis_tready = (state_q == ST_IDLE) && (!ovld_q || m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    mid_sum = {1'b0, lo_q} + {2'b00, width_q};
    mid_c   = (mid_sum >= {2'b00, cnt_q}) ? cnt_q : mid_sum[CW-1:0];
    hi_sum  = {2'b00, mid_c} + {2'b00, width_q};
    hi_c    = (hi_sum >= {2'b00, cnt_q}) ? cnt_q : hi_sum[CW-1:0];
    lo_next = {1'b0, lo_q} + {1'b0, width_q, 1'b0};
    width_dbl = {width_q[CW-2:0], 1'b0};
    av_a    = i_q < mid_q;
    av_b    = j_q < hi_q;
    take_b  = av_b && (!av_a || (b_q[EW-1:64] < a_q[EW-1:64]));
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    cur_d     = cur_q;
    idx_d     = idx_q;
    w_d       = w_q;
    key_d     = key_q;
    acc_key_d = acc_key_q;
    acc_val_d = acc_val_q;
    width_d   = width_q;
    lo_d      = lo_q;
    mid_d     = mid_q;
    hi_d      = hi_q;
    i_d       = i_q;
    j_d       = j_q;
    k_d       = k_q;
    a_d       = a_q;
    b_d       = b_q;
    first_d   = first_q;

    res_load  = 1'b0;
    res_val   = 64'd0;
    res_row   = 32'd0;
    res_col   = 32'd0;
    res_found = 1'b0;
    res_stat  = stac_pkg::STAT_OK;

    we        = 1'b0;
    wbank     = cur_q;
    waddr     = w_q;
    wdata     = {acc_key_q, acc_val_q};
    raddr     = in_pos;

    add_req.start = 1'b0;
    add_req.a     = acc_val_q;
    add_req.b     = rdata[63:0];

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_mode)
            stac_pkg::MODE_CLEAR: begin
              cnt_d    = '0;
              res_load = 1'b1;
            end
            stac_pkg::MODE_INSERT: begin
              res_load = 1'b1;
              if ((in_row >= row_lim_q) || (in_col >= col_lim_q)) begin
                res_stat = stac_pkg::STAT_RANGE;
              end else if (cnt_q >= CW'(stac_pkg::CAPACITY)) begin
                res_stat = stac_pkg::STAT_FULL;
              end else begin
                we    = 1'b1;
                waddr = cnt_q[AW-1:0];
                wdata = {in_col, in_row, in_val};
                cnt_d = cnt_q + CW'(1);
              end
            end
            stac_pkg::MODE_SORT: begin
              if (cnt_q <= CW'(1)) begin
                res_load = 1'b1;
              end else begin
                width_d = CW'(1);
                lo_d    = '0;
                state_d = ST_SO_SETUP;
              end
            end
            stac_pkg::MODE_COMPACT: begin
              if (cnt_q == '0) begin
                res_load = 1'b1;
              end else begin
                raddr   = '0;
                state_d = ST_CP_FIRST;
              end
            end
            stac_pkg::MODE_LOOKUP: begin
              if (cnt_q == '0) begin
                res_load = 1'b1;
              end else begin
                raddr   = '0;
                key_d   = {in_col, in_row};
                idx_d   = '0;
                state_d = ST_LK;
              end
            end
            stac_pkg::MODE_READ: begin
              if ({1'b0, in_pos} >= cnt_q) begin
                res_load = 1'b1;
                res_stat = stac_pkg::STAT_POS;
              end else begin
                raddr   = in_pos;
                state_d = ST_RD;
              end
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      ST_RD: begin
        res_load = 1'b1;
        res_val  = rdata[63:0];
        res_row  = rdata[95:64];
        res_col  = rdata[127:96];
        state_d  = ST_IDLE;
      end
      ST_LK: begin
        raddr = AW'(idx_q + CW'(1));
        if (rdata[127:64] == key_q) begin
          res_load  = 1'b1;
          res_found = 1'b1;
          res_val   = rdata[63:0];
          state_d   = ST_IDLE;
        end else if (idx_q + CW'(1) == cnt_q) begin
          res_load = 1'b1;
          state_d  = ST_IDLE;
        end else begin
          idx_d = idx_q + CW'(1);
        end
      end
      ST_CP_FIRST: begin
        acc_key_d = rdata[127:64];
        acc_val_d = rdata[63:0];
        idx_d     = CW'(1);
        w_d       = '0;
        state_d   = (cnt_q == CW'(1)) ? ST_CP_END : ST_CP_ISSUE;
      end
      ST_CP_ISSUE: begin
        raddr   = idx_q[AW-1:0];
        state_d = ST_CP_RUN;
      end
      ST_CP_RUN: begin
        if (rdata[127:64] == acc_key_q) begin
          add_req.start = 1'b1;
          state_d       = ST_CP_ADD;
        end else begin
          // flush the finished run and start a new one
          we        = 1'b1;
          w_d       = w_q + AW'(1);
          acc_key_d = rdata[127:64];
          acc_val_d = rdata[63:0];
          idx_d     = idx_q + CW'(1);
          state_d   = (idx_q + CW'(1) == cnt_q) ? ST_CP_END : ST_CP_ISSUE;
        end
      end
      ST_CP_ADD: begin
        if (add_rsp.done) begin
          acc_val_d = add_rsp.sum;
          idx_d     = idx_q + CW'(1);
          state_d   = (idx_q + CW'(1) == cnt_q) ? ST_CP_END : ST_CP_ISSUE;
        end
      end
      ST_CP_END: begin
        we       = 1'b1;
        cnt_d    = {1'b0, w_q} + CW'(1);
        res_load = 1'b1;
        state_d  = ST_IDLE;
      end
      ST_SO_SETUP: begin
        mid_d   = mid_c;
        hi_d    = hi_c;
        i_d     = lo_q[CW-1:0];
        j_d     = mid_c;
        k_d     = lo_q[CW-1:0];
        raddr   = lo_q[AW-1:0];
        first_d = 1'b1;
        state_d = ST_SO_LDA;
      end
      ST_SO_LDA: begin
        a_d = rdata;
        if (first_q) begin
          raddr   = mid_q[AW-1:0];
          first_d = 1'b0;
          state_d = ST_SO_LDB;
        end else begin
          state_d = ST_SO_CMP;
        end
      end
      ST_SO_LDB: begin
        b_d     = rdata;
        state_d = ST_SO_CMP;
      end
      ST_SO_CMP: begin
        wbank = !cur_q;
        waddr = k_q[AW-1:0];
        wdata = take_b ? b_q : a_q;
        if (!av_a && !av_b) begin
          if (lo_next >= {2'b00, cnt_q}) begin
            // pass complete: destination bank becomes the source
            cur_d   = !cur_q;
            width_d = width_dbl;
            lo_d    = '0;
            if (width_dbl >= cnt_q) begin
              res_load = 1'b1;
              state_d  = ST_IDLE;
            end else begin
              state_d = ST_SO_SETUP;
            end
          end else begin
            lo_d    = lo_next[CW:0];
            state_d = ST_SO_SETUP;
          end
        end else begin
          we  = 1'b1;
          k_d = k_q + CW'(1);
          if (take_b) begin
            j_d     = j_q + CW'(1);
            raddr   = AW'(j_q + CW'(1));
            state_d = ST_SO_LDB;
          end else begin
            i_d     = i_q + CW'(1);
            raddr   = AW'(i_q + CW'(1));
            state_d = ST_SO_LDA;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      cur_q     <= 1'b0;
      row_lim_q <= 32'hFFFF_FFFF;
      col_lim_q <= 32'hFFFF_FFFF;
      ovld_q    <= 1'b0;
      first_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      cur_q   <= cur_d;
      first_q <= first_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == stac_pkg::REG_ROW_LIMIT) begin
          row_lim_q <= cfg_data_i;
        end else begin
          col_lim_q <= cfg_data_i;
        end
      end
      if (res_load) begin
        ovld_q <= 1'b1;
      end else if (m_axis_tready) begin
        ovld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    w_q       <= w_d;
    key_q     <= key_d;
    acc_key_q <= acc_key_d;
    acc_val_q <= acc_val_d;
    width_q   <= width_d;
    lo_q      <= lo_d;
    mid_q     <= mid_d;
    hi_q      <= hi_d;
    i_q       <= i_d;
    j_q       <= j_d;
    k_q       <= k_d;
    a_q       <= a_d;
    b_q       <= b_d;
    if (res_load) begin
      o_val_q   <= res_val;
      o_row_q   <= res_row;
      o_col_q   <= res_col;
      o_found_q <= res_found;
      o_cnt_q   <= cnt_d;
      o_stat_q  <= res_stat;
    end
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = {4'd0, o_cnt_q, o_found_q, o_col_q, o_row_q, o_val_q};
  assign m_axis_tuser  = o_stat_q;

endmodule

// ===== test/sparse_triplet_accumulator_unit_tb.sv =====
// Self-checking testbench for sparse_triplet_accumulator_unit: directed and random
// operation streams, checked against a behavioral model of the triplet store.
// Depends on stac_pkg and the RTL of the block.
`timescale 1ns / 1ps
module sparse_triplet_accumulator_unit_tb;

  localparam logic [2:0] MODE_SPARE_6 = 3'd6;
  localparam logic [2:0] MODE_SPARE_7 = 3'd7;
  localparam logic [63:0] F64_POS_INF = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] F64_NEG_INF = 64'hFFF0_0000_0000_0000;
  localparam logic [63:0] F64_QNAN    = 64'h7FF8_0000_0000_0001;
  localparam logic [63:0] F64_ONE     = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] F64_HALF    = 64'h3FE0_0000_0000_0000;

  typedef struct {
    logic [63:0] value;
    logic [31:0] row;
    logic [31:0] col;
    logic        found;
    logic [10:0] count;
    logic [1:0]  status;
  } triplet_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [143:0] s_axis_tdata = '0;
  logic [2:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [143:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         cfg_we_i = 1'b0;
  logic         cfg_idx_i = 1'b0;
  logic [31:0]  cfg_data_i = '0;

  sparse_triplet_accumulator_unit dut (.*);

  always #1 clk_i = ~clk_i;

  // Model copy of the store and registers
  logic [63:0] mdl_keys [stac_pkg::CAPACITY];
  logic [63:0] mdl_vals [stac_pkg::CAPACITY];
  int unsigned mdl_count;
  logic [31:0] mdl_row_limit;
  logic [31:0] mdl_col_limit;

  triplet_result_t expected_results [$];
  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned burst_left = 0;
  int unsigned stall_pct = 0;

  function automatic logic [63:0] f64_add(logic [63:0] a, logic [63:0] b);
    return $realtobits($bitstoreal(a) + $bitstoreal(b));
  endfunction

  function automatic triplet_result_t store_apply(logic [2:0] mode, logic [31:0] row,
      logic [31:0] col, logic [63:0] vbits, logic [9:0] pos);
    triplet_result_t r;
    logic [63:0] key, k, v;
    int unsigned i, j, w;
    r = '{default: '0};
    key = {col, row};
    case (mode)
      stac_pkg::MODE_CLEAR: mdl_count = 0;
      stac_pkg::MODE_INSERT: begin
        if (row >= mdl_row_limit || col >= mdl_col_limit) r.status = stac_pkg::STAT_RANGE;
        else if (mdl_count >= stac_pkg::CAPACITY) r.status = stac_pkg::STAT_FULL;
        else begin
          mdl_keys[mdl_count] = key;
          mdl_vals[mdl_count] = vbits;
          mdl_count++;
        end
      end
      stac_pkg::MODE_SORT: begin
        // stable insertion sort: equal keys keep insertion order
        for (i = 1; i < mdl_count; i++) begin
          k = mdl_keys[i];
          v = mdl_vals[i];
          j = i;
          while (j > 0 && mdl_keys[j-1] > k) begin
            mdl_keys[j] = mdl_keys[j-1];
            mdl_vals[j] = mdl_vals[j-1];
            j--;
          end
          mdl_keys[j] = k;
          mdl_vals[j] = v;
        end
      end
      stac_pkg::MODE_COMPACT: begin
        if (mdl_count != 0) begin
          w = 0;
          for (i = 1; i < mdl_count; i++) begin
            if (mdl_keys[i] == mdl_keys[w]) mdl_vals[w] = f64_add(mdl_vals[w], mdl_vals[i]);
            else begin
              w++;
              mdl_keys[w] = mdl_keys[i];
              mdl_vals[w] = mdl_vals[i];
            end
          end
          mdl_count = w + 1;
        end
      end
      stac_pkg::MODE_LOOKUP: begin
        for (i = 0; i < mdl_count && !r.found; i++) begin
          if (mdl_keys[i] == key) begin
            r.value = mdl_vals[i];
            r.found = 1'b1;
          end
        end
      end
      stac_pkg::MODE_READ: begin
        if (pos >= mdl_count) r.status = stac_pkg::STAT_POS;
        else begin
          r.value = mdl_vals[pos];
          r.row = mdl_keys[pos][31:0];
          r.col = mdl_keys[pos][63:32];
        end
      end
      default: ;
    endcase
    r.count = mdl_count[10:0];
    return r;
  endfunction

  task automatic send_op(logic [2:0] mode, logic [31:0] row = '0, logic [31:0] col = '0,
      logic [63:0] vbits = '0, logic [9:0] pos = '0);
    int unsigned gap;
    triplet_result_t exp_r;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      repeat (gap) begin
        @(negedge clk_i);
        s_axis_tvalid = 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser = mode;
    s_axis_tdata = {6'b0, pos, vbits, col, row};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    exp_r = store_apply(mode, row, col, vbits, pos);
    expected_results.insert(expected_results.size(), exp_r);
    items_sent++;
  endtask

  task automatic wait_all_results();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_limits(logic [31:0] row_lim, logic [31:0] col_lim);
    wait_all_results();
    repeat (8) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = stac_pkg::REG_ROW_LIMIT;
    cfg_data_i = row_lim;
    @(negedge clk_i);
    cfg_idx_i = stac_pkg::REG_COL_LIMIT;
    cfg_data_i = col_lim;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    mdl_row_limit = row_lim;
    mdl_col_limit = col_lim;
  endtask

  // Receiver: stall rate changes now and then, including stretches with no stall
  always @(negedge clk_i) begin
    if ($urandom_range(0, 63) == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 20;
        2: stall_pct = 50;
        default: stall_pct = 85;
      endcase
    end
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    triplet_result_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (m_axis_tdata[63:0] !== e.value) begin
          $error("out_value_bits exp %h got %h", e.value, m_axis_tdata[63:0]);
          errors++;
        end
        if (m_axis_tdata[95:64] !== e.row) begin
          $error("out_row exp %h got %h", e.row, m_axis_tdata[95:64]);
          errors++;
        end
        if (m_axis_tdata[127:96] !== e.col) begin
          $error("out_col exp %h got %h", e.col, m_axis_tdata[127:96]);
          errors++;
        end
        if (m_axis_tdata[128] !== e.found) begin
          $error("found exp %b got %b", e.found, m_axis_tdata[128]);
          errors++;
        end
        if (m_axis_tdata[139:129] !== e.count) begin
          $error("entry_count exp %0d got %0d", e.count, m_axis_tdata[139:129]);
          errors++;
        end
        if (m_axis_tuser !== e.status) begin
          $error("status exp %0d got %0d", e.status, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  task automatic test_basic_ops();
    send_op(stac_pkg::MODE_SORT);
    send_op(stac_pkg::MODE_COMPACT);
    send_op(stac_pkg::MODE_READ, '0, '0, '0, 10'd0);
    send_op(stac_pkg::MODE_INSERT, 32'h0, 32'h0, 64'h0);
    send_op(stac_pkg::MODE_INSERT, 32'hFFFF_FFFE, 32'hFFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFF);
    send_op(stac_pkg::MODE_INSERT, 32'hFFFF_FFFF, 32'h5, F64_ONE);  // row at limit
    send_op(stac_pkg::MODE_INSERT, 32'h5, 32'hFFFF_FFFF, F64_ONE);  // column at limit
    send_op(stac_pkg::MODE_LOOKUP, 32'hFFFF_FFFE, 32'hFFFF_FFFE);
    send_op(stac_pkg::MODE_LOOKUP, 32'h1, 32'h0);
    send_op(stac_pkg::MODE_READ, '0, '0, '0, 10'd1);
    send_op(stac_pkg::MODE_READ, '0, '0, '0, 10'd2);
    send_op(stac_pkg::MODE_READ, '0, '0, '0, 10'h3FF);
    send_op(MODE_SPARE_6, 32'h1, 32'h2, F64_ONE, 10'd1);
    send_op(MODE_SPARE_7);
    send_op(stac_pkg::MODE_CLEAR);
    send_op(stac_pkg::MODE_READ, '0, '0, '0, 10'd0);
  endtask

  task automatic test_merge_special_values();
    send_op(stac_pkg::MODE_INSERT, 32'd3, 32'd1, F64_ONE);
    send_op(stac_pkg::MODE_INSERT, 32'd1, 32'd1, F64_POS_INF);
    send_op(stac_pkg::MODE_INSERT, 32'd3, 32'd1, F64_HALF);
    send_op(stac_pkg::MODE_INSERT, 32'd0, 32'd2, F64_QNAN);
    send_op(stac_pkg::MODE_INSERT, 32'd1, 32'd1, F64_NEG_INF);
    send_op(stac_pkg::MODE_INSERT, 32'd0, 32'd2, F64_ONE);
    send_op(stac_pkg::MODE_LOOKUP, 32'd3, 32'd1);
    send_op(stac_pkg::MODE_SORT);
    send_op(stac_pkg::MODE_READ, '0, '0, '0, 10'd2);
    send_op(stac_pkg::MODE_READ, '0, '0, '0, 10'd3);
    send_op(stac_pkg::MODE_COMPACT);
    for (int p = 0; p < 4; p++) send_op(stac_pkg::MODE_READ, '0, '0, '0, p[9:0]);
    send_op(stac_pkg::MODE_CLEAR);
  endtask

  task automatic test_limit_registers();
    write_limits(32'd1, 32'd1);
    send_op(stac_pkg::MODE_INSERT, 32'd0, 32'd0, F64_ONE);
    send_op(stac_pkg::MODE_INSERT, 32'd1, 32'd0, F64_ONE);
    send_op(stac_pkg::MODE_INSERT, 32'd0, 32'd1, F64_ONE);
    send_op(stac_pkg::MODE_CLEAR);
    write_limits(32'h8000_0000, 32'h0000_0100);
    send_op(stac_pkg::MODE_INSERT, 32'h7FFF_FFFF, 32'h0FF, F64_ONE);
    send_op(stac_pkg::MODE_INSERT, 32'h8000_0000, 32'h0FF, F64_ONE);
    send_op(stac_pkg::MODE_INSERT, 32'h0, 32'h100, F64_ONE);
    send_op(stac_pkg::MODE_CLEAR);
    write_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_full_store();
    // few distinct keys so the full-size sort and compact merge heavily
    for (int i = 0; i < stac_pkg::CAPACITY; i++)
      send_op(stac_pkg::MODE_INSERT, $urandom_range(0, 3), $urandom_range(0, 1),
              {2'b0, 10'h3F0, $urandom_range(0, 1) ? 20'h0 : 20'hFFFFF, 32'($urandom)});
    send_op(stac_pkg::MODE_INSERT, 32'd0, 32'd0, F64_ONE);
    // range checked before fullness
    send_op(stac_pkg::MODE_INSERT, 32'hFFFF_FFFF, 32'd0, F64_ONE);
    send_op(stac_pkg::MODE_READ, '0, '0, '0, 10'h3FF);
    send_op(stac_pkg::MODE_LOOKUP, 32'd9, 32'd9);
    send_op(stac_pkg::MODE_SORT);
    send_op(stac_pkg::MODE_COMPACT);
    for (int p = 0; p < 9; p++) send_op(stac_pkg::MODE_READ, '0, '0, '0, p[9:0]);
    send_op(stac_pkg::MODE_CLEAR);
  endtask

  task automatic test_random_sequences(int unsigned n_items);
    logic [31:0] pool_row [4];
    logic [31:0] pool_col [4];
    int unsigned start, k, n, sel;
    start = items_sent;
    while (items_sent - start < n_items) begin
      if ((items_sent - start) > n_items / 2 && (items_sent - start) < n_items / 2 + 40)
        wait_all_results();
      for (int i = 0; i < 4; i++) begin
        pool_row[i] = $urandom_range(0, 2) == 0 ? $urandom : $urandom_range(0, 7);
        pool_col[i] = $urandom_range(0, 2) == 0 ? $urandom : $urandom_range(0, 7);
      end
      if ($urandom_range(0, 3) != 0) send_op(stac_pkg::MODE_CLEAR);
      n = $urandom_range(1, 20);
      for (int i = 0; i < n; i++) begin
        k = $urandom_range(0, 3);
        if ($urandom_range(0, 9) == 0)
          send_op(3'($urandom_range(0, 7)), $urandom, $urandom, {$urandom, $urandom},
                  10'($urandom));
        else
          send_op(stac_pkg::MODE_INSERT, pool_row[k], pool_col[k], {$urandom, $urandom});
      end
      if ($urandom_range(0, 3) != 0) send_op(stac_pkg::MODE_SORT);
      sel = $urandom_range(0, 4);
      for (int i = 0; i < sel; i++) begin
        k = $urandom_range(0, 3);
        send_op(stac_pkg::MODE_LOOKUP, pool_row[k],
                $urandom_range(0, 4) == 0 ? $urandom : pool_col[k]);
      end
      if ($urandom_range(0, 2) != 0) send_op(stac_pkg::MODE_COMPACT);
      sel = $urandom_range(1, 5);
      for (int i = 0; i < sel; i++)
        send_op(stac_pkg::MODE_READ, '0, '0, '0,
                $urandom_range(0, 5) == 0 ? 10'($urandom) : 10'($urandom_range(0, mdl_count + 1)));
    end
  endtask

  initial begin
    mdl_count = 0;
    mdl_row_limit = 32'hFFFF_FFFF;
    mdl_col_limit = 32'hFFFF_FFFF;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    test_basic_ops();
    test_merge_special_values();
    test_limit_registers();
    test_full_store();
    test_random_sequences(100);
    write_limits(32'd6, 32'd5);
    test_random_sequences(80);
    write_limits(32'd1, 32'hFFFF_FFFF);
    test_random_sequences(50);
    write_limits($urandom | 32'h1, $urandom | 32'h1);
    test_random_sequences(50);
    write_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    test_random_sequences(90);
    wait_all_results();
    repeat (50) @(negedge clk_i);
    $display("Ran %0d operations, %0d results checked: clear, insert, sort, compact,",
             items_sent, results_seen);
    $display("lookup and read, full store, range limits and special float values.");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== sparse_triplet_accumulator_unit.f =====
rtl/stac_pkg.sv
rtl/stac_ram.sv
rtl/stac_fp_add.sv
rtl/sparse_triplet_accumulator_unit.sv
test/sparse_triplet_accumulator_unit_tb.sv
